>>> hw/rtl/ssq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssq_pkg;

    // Field widths fixed by the stream format
    localparam int DIR_W        = 3;
    localparam int FIELD_W      = 16;
    localparam int PAT_W        = 4;
    localparam int POS_W        = 16;
    localparam int PATTERN_W    = 32;
    localparam int PATTERN_SLOTS = PATTERN_W / PAT_W;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 24;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 32;

    // Item kinds carried on tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEPS     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_TABLE = 1'b1;

    // Configuration reset values
    localparam logic [FIELD_W-1:0]   MIN_STEPS_RST = 16'd4;
    localparam logic [PATTERN_W-1:0] PATTERN_RST   = 32'h913264C8;

    // Step mode limits
    localparam logic signed [DIR_W-1:0] MODE_MAX  = 3'sd2;
    localparam logic signed [DIR_W-1:0] MODE_MIN  = -3'sd2;
    localparam logic signed [DIR_W-1:0] MODE_STOP = 3'sd0;

    typedef struct packed {
        logic                      opcode;
        logic                      limit_switch;
        logic signed [DIR_W-1:0]   move_direction;
        logic [FIELD_W-1:0]        move_steps;
        logic                      move_continuous;
        logic [FIELD_W-1:0]        move_period;
    } ssq_item_t;

    typedef struct packed {
        logic [PAT_W-1:0]          coil_pattern;
        logic [POS_W-1:0]          position;
        logic signed [DIR_W-1:0]   step_mode;
        logic                      step_event;
    } ssq_result_t;

    typedef struct packed {
        logic [FIELD_W-1:0]        min_steps;
        logic [PATTERN_W-1:0]      pattern_table;
    } ssq_cfg_t;

    // Clamp a requested direction to the legal step modes
    function automatic logic signed [DIR_W-1:0] clamp_mode(
        input logic signed [DIR_W-1:0] dir
    );
        logic signed [DIR_W-1:0] m;
        m = dir;
        if (dir > MODE_MAX)
        begin
            m = MODE_MAX;
        end
        else if (dir < MODE_MIN)
        begin
            m = MODE_MIN;
        end
        return m;
    endfunction

    // Coil pattern at a table slot; slots past the stored eight read as zero
    function automatic logic [PAT_W-1:0] pattern_at(
        input logic [PATTERN_W-1:0] tbl,
        input logic [3:0]           idx
    );
        logic [PAT_W-1:0] p;
        p = '0;
        if (idx < 4'(PATTERN_SLOTS))
        begin
            p = tbl[idx[2:0]*PAT_W +: PAT_W];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssq_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ssq_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [ssq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ssq_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ssq_pkg::ssq_cfg_t                     cfg
);
    import ssq_pkg::*;

    logic [FIELD_W-1:0]   min_steps_reg;
    logic [PATTERN_W-1:0] pattern_reg;

    // Register writes, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_steps_reg <= MIN_STEPS_RST;
            pattern_reg   <= PATTERN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_STEPS:     min_steps_reg <= cfg_data[FIELD_W-1:0];
                REG_PATTERN_TABLE: pattern_reg   <= cfg_data[PATTERN_W-1:0];
            endcase
        end
    end

    assign cfg.min_steps     = min_steps_reg;
    assign cfg.pattern_table = pattern_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ssq_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ssq_core #(
    parameter int TABLE_ENTRIES = 8,
    parameter int COUNT_WIDTH   = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  ssq_pkg::ssq_item_t  item,
    input  ssq_pkg::ssq_cfg_t   cfg,
    output ssq_pkg::ssq_result_t result
);
    import ssq_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int SUM_W = IDX_W + 2;
    localparam logic signed [SUM_W-1:0] N_S = SUM_W'(TABLE_ENTRIES);
    localparam logic [COUNT_WIDTH-1:0]  ONE = COUNT_WIDTH'(1);

    logic [IDX_W-1:0]          index_reg,     index_next;
    logic signed [DIR_W-1:0]   mode_reg,      mode_next;
    logic [POS_W-1:0]          position_reg,  position_next;
    logic [COUNT_WIDTH-1:0]    steps_reg,     steps_next;
    logic [COUNT_WIDTH-1:0]    limit_reg,     limit_next;
    logic                      cont_reg,      cont_next;
    logic [COUNT_WIDTH-1:0]    period_reg,    period_next;
    logic [COUNT_WIDTH-1:0]    countdown_reg, countdown_next;

    logic [COUNT_WIDTH+FIELD_W-1:0] period_wide;
    logic [COUNT_WIDTH+FIELD_W-1:0] limit_wide;
    logic [COUNT_WIDTH-1:0]         move_period_c;
    logic signed [SUM_W-1:0]        index_sum;
    logic [COUNT_WIDTH+FIELD_W-1:0] steps_cmp;
    logic [COUNT_WIDTH+FIELD_W-1:0] min_cmp;
    logic                           event_flag;

    // Move fields fitted to the counter width
    assign period_wide   = {COUNT_WIDTH'(0), item.move_period};
    assign limit_wide    = {COUNT_WIDTH'(0), item.move_steps};
    assign move_period_c = period_wide[COUNT_WIDTH-1:0];

    // Table index moved by the current mode, wrapped into the table
    assign index_sum = $signed({2'b00, index_reg}) + SUM_W'(mode_reg);

    always_comb
    begin
        index_next     = index_reg;
        mode_next      = mode_reg;
        position_next  = position_reg;
        steps_next     = steps_reg;
        limit_next     = limit_reg;
        cont_next      = cont_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        event_flag     = 1'b0;
        steps_cmp      = '0;
        min_cmp        = '0;

        if (item.opcode == OP_MOVE)
        begin
            // Move command: load the move, countdown holds its value
            mode_next   = clamp_mode(item.move_direction);
            steps_next  = '0;
            period_next = (move_period_c == '0) ? ONE : move_period_c;
            limit_next  = limit_wide[COUNT_WIDTH-1:0];
            cont_next   = item.move_continuous;
        end
        else if (countdown_reg > ONE)
        begin
            countdown_next = countdown_reg - ONE;
        end
        else
        begin
            // Period expired: step the index, position and step count
            event_flag     = 1'b1;
            countdown_next = period_reg;
            if (index_sum < 0)
            begin
                index_next = IDX_W'(index_sum + N_S);
            end
            else if (index_sum >= N_S)
            begin
                index_next = IDX_W'(index_sum - N_S);
            end
            else
            begin
                index_next = IDX_W'(index_sum);
            end

            if (mode_reg != MODE_STOP)
            begin
                position_next = position_reg + {{(POS_W-DIR_W){mode_reg[DIR_W-1]}}, mode_reg};
                if (steps_reg != '1)
                begin
                    steps_next = steps_reg + ONE;
                end
            end

            // Stop on a limit switch press past min_steps or an exhausted step budget
            steps_cmp = {FIELD_W'(0), steps_next};
            min_cmp   = {COUNT_WIDTH'(0), cfg.min_steps};
            if ((item.limit_switch && (steps_cmp > min_cmp)) ||
                (!cont_reg && (steps_next > limit_reg)))
            begin
                mode_next = MODE_STOP;
                cont_next = 1'b1;
            end
        end
    end

    // State registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            mode_reg      <= MODE_STOP;
            position_reg  <= '0;
            steps_reg     <= '0;
            limit_reg     <= '0;
            cont_reg      <= 1'b1;
            period_reg    <= ONE;
            countdown_reg <= ONE;
        end
        else if (fire)
        begin
            index_reg     <= index_next;
            mode_reg      <= mode_next;
            position_reg  <= position_next;
            steps_reg     <= steps_next;
            limit_reg     <= limit_next;
            cont_reg      <= cont_next;
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
        end
    end

    // Result reflects the state after this item
    assign result.coil_pattern = pattern_at(cfg.pattern_table, 4'(index_next));
    assign result.position     = position_next;
    assign result.step_mode    = mode_next;
    assign result.step_event   = event_flag;

endmodule

`default_nettype wire

>>> hw/rtl/stepper_step_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Stepper coil sequencer. Each tick transaction counts the step period down;
// on expiry the coil table index moves by the signed step mode and the new
// pattern, position and mode are reported with step_event set. A move
// transaction loads mode, period, step count and continuous flag. Exactly one
// result leaves for every input transaction, in order. Throughput is one
// transaction per clock when m_tready does not stall the result register:
// the whole update is a single pass of adds and compares between the input
// register and the result register, which each transaction passes in turn.
// Configuration writes are taken every cycle (cfg_ready is always high) and
// belong to idle periods.
module stepper_step_sequencer #(
    parameter int TABLE_ENTRIES = 8,
    parameter int COUNT_WIDTH   = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // tdata: limit_switch, move_direction[2:0], move_steps[15:0],
    //        move_continuous, move_period[15:0], zero pad
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [ssq_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: opcode
    input  wire logic                             s_tuser,
    // tdata: coil_pattern[3:0], position[15:0], step_mode[2:0], step_event
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [ssq_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [ssq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ssq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssq_pkg::*;

    logic        in_valid_reg;
    ssq_item_t   in_item_reg;
    logic        out_valid_reg;
    ssq_result_t out_result_reg;
    ssq_result_t result;
    ssq_cfg_t    cfg;
    logic        advance;
    logic        s_fire;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.opcode          <= s_tuser;
            in_item_reg.limit_switch    <= s_tdata[0];
            in_item_reg.move_direction  <= s_tdata[3:1];
            in_item_reg.move_steps      <= s_tdata[19:4];
            in_item_reg.move_continuous <= s_tdata[20];
            in_item_reg.move_period     <= s_tdata[36:21];
        end
    end

    ssq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssq_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.step_event, out_result_reg.step_mode,
                       out_result_reg.position, out_result_reg.coil_pattern};

    // Reported mode is always a legal step mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[22:20] != 3'b011 && m_tdata[22:20] != 3'b100 &&
                      m_tdata[22:20] != 3'b101))
        else $error("step mode out of range");

    // A move transaction never reports a step
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.opcode == OP_MOVE) |=> !out_result_reg.step_event)
        else $error("step event on move transaction");

    // With the result register empty the input side keeps flowing
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

>>> dv/stepper_step_sequencer_tb.sv
`timescale 1ns / 1ps

module stepper_step_sequencer_tb;

    import ssq_pkg::*;

    // Tracks the sequencer state and holds the results it must produce, in order
    class coil_scoreboard;
        logic [2:0]              slot;
        logic signed [DIR_W-1:0] mode;
        logic [POS_W-1:0]        position;
        logic [FIELD_W-1:0]      steps_taken;
        logic [FIELD_W-1:0]      steps_wanted;
        logic                    free_running;
        logic [FIELD_W-1:0]      period;
        logic [FIELD_W-1:0]      ticks_left;
        logic [FIELD_W-1:0]      min_steps;
        logic [PATTERN_W-1:0]    coil_bits;
        ssq_result_t             coil_expected[$];
        int                      mismatches;

        function new();
            slot         = '0;
            mode         = MODE_STOP;
            position     = '0;
            steps_taken  = '0;
            steps_wanted = '0;
            free_running = 1'b1;
            period       = 16'd1;
            ticks_left   = 16'd1;
            min_steps    = MIN_STEPS_RST;
            coil_bits    = PATTERN_RST;
            mismatches   = 0;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 30)
            begin
                $display("ERROR @%0t: %s", $time, msg);
            end
        endtask

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_MIN_STEPS)
            begin
                min_steps = val[FIELD_W-1:0];
            end
            else
            begin
                coil_bits = val;
            end
        endfunction

        // Next sequencer output for one accepted item
        function ssq_result_t predict_coil(ssq_item_t it);
            ssq_result_t             r;
            logic signed [DIR_W-1:0] m;
            r.step_event = 1'b0;
            if (it.opcode == OP_MOVE)
            begin
                m = it.move_direction;
                if (m > MODE_MAX)
                begin
                    m = MODE_MAX;
                end
                else if (m < MODE_MIN)
                begin
                    m = MODE_MIN;
                end
                steps_taken  = '0;
                period       = (it.move_period == '0) ? 16'd1 : it.move_period;
                steps_wanted = it.move_steps;
                free_running = it.move_continuous;
                mode         = m;
            end
            else if (ticks_left > 16'd1)
            begin
                ticks_left = ticks_left - 16'd1;
            end
            else
            begin
                // period expired: advance the table and test the stop conditions
                ticks_left = period;
                slot = slot + mode;
                if (mode != MODE_STOP)
                begin
                    position = position + {{(POS_W-DIR_W){mode[DIR_W-1]}}, mode};
                    if (steps_taken != 16'hFFFF)
                    begin
                        steps_taken = steps_taken + 16'd1;
                    end
                end
                if ((it.limit_switch && steps_taken > min_steps) ||
                    (!free_running && steps_taken > steps_wanted))
                begin
                    mode         = MODE_STOP;
                    free_running = 1'b1;
                end
                r.step_event = 1'b1;
            end
            r.coil_pattern = coil_bits[slot*PAT_W +: PAT_W];
            r.position     = position;
            r.step_mode    = mode;
            return r;
        endfunction

        function void note_item(ssq_item_t it);
            coil_expected.push_back(predict_coil(it));
        endfunction

        task check_result(logic [M_TDATA_W-1:0] d);
            ssq_result_t want;
            if (coil_expected.size() == 0)
            begin
                report($sformatf("result %h with nothing expected", d));
            end
            else
            begin
                want = coil_expected.pop_front();
                if (d[3:0] !== want.coil_pattern)
                begin
                    report($sformatf("coil_pattern %h, expected %h", d[3:0], want.coil_pattern));
                end
                if (d[19:4] !== want.position)
                begin
                    report($sformatf("position %h, expected %h", d[19:4], want.position));
                end
                if (d[22:20] !== want.step_mode)
                begin
                    report($sformatf("step_mode %h, expected %h", d[22:20], want.step_mode));
                end
                if (d[23] !== want.step_event)
                begin
                    report($sformatf("step_event %b, expected %b", d[23], want.step_event));
                end
            end
        endtask

        function int pending();
            return coil_expected.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    coil_scoreboard sb;
    int             burst_left;
    bit             hold_request;

    stepper_step_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Offer one item; bursts of random length separated by random gaps
    task push_item(ssq_item_t it);
        s_tdata  <= {3'b000, it.move_period, it.move_continuous, it.move_steps,
                     it.move_direction, it.limit_switch};
        s_tuser  <= it.opcode;
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_item(it);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Tick with random filler in the fields a tick ignores
    task push_tick(logic sw);
        ssq_item_t   it;
        logic [63:0] rnd;
        rnd                = {$urandom, $urandom};
        it                 = rnd[$bits(ssq_item_t)-1:0];
        it.opcode          = OP_TICK;
        it.limit_switch    = sw;
        push_item(it);
    endtask

    task push_move(int dir, logic [FIELD_W-1:0] steps, logic cont, logic [FIELD_W-1:0] per);
        ssq_item_t it;
        it.opcode          = OP_MOVE;
        it.limit_switch    = 1'($urandom_range(0, 1));
        it.move_direction  = DIR_W'(dir);
        it.move_steps      = steps;
        it.move_continuous = cont;
        it.move_period     = per;
        push_item(it);
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Both registers, back to back; only called with the block idle
    task write_config(logic [FIELD_W-1:0] min_val, logic [PATTERN_W-1:0] pat_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MIN_STEPS;
        cfg_data  <= {16'h0000, min_val};
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.write_register(REG_MIN_STEPS, {16'h0000, min_val});
        cfg_index <= REG_PATTERN_TABLE;
        cfg_data  <= pat_val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.write_register(REG_PATTERN_TABLE, pat_val);
        cfg_valid <= 1'b0;
    endtask

    // Mostly move-then-ticks sequences; some moves are immediately overridden
    task run_random(int n, bit with_hold);
        int cnt;
        int dir;
        int k;
        bit hold_done;
        cnt       = 0;
        hold_done = 1'b0;
        while (cnt < n)
        begin
            if (with_hold && !hold_done && cnt >= n / 2)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    push_move($urandom_range(0, 7), 16'($urandom), 1'($urandom_range(0, 1)),
                              16'($urandom));
                    cnt++;
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    dir = $urandom_range(0, 7);
                end
                else
                begin
                    dir = int'($urandom_range(0, 4)) - 2;
                end
                push_move(dir,
                          ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 10)),
                          ($urandom_range(0, 3) == 0), 16'($urandom_range(0, 3)));
                cnt++;
                k = $urandom_range(1, 24);
                repeat (k) push_tick($urandom_range(0, 7) == 0);
                cnt += k;
            end
            else
            begin
                push_tick(1'($urandom_range(0, 1)));
                cnt++;
            end
        end
        drain_results();
    endtask

    // Receiver: ready pattern changes every so often; one long hold on request
    initial
    begin
        int style;
        int style_left;
        m_tready   <= 1'b0;
        style      = 0;
        style_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(32, 256);
            end
            style_left--;
            case (style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        sb           = new();
        burst_left   = 0;
        hold_request = 1'b0;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, zero period, count stop, clamping, switch stop
        push_tick(1'b0);
        push_move(1, 16'd3, 1'b0, 16'd0);
        repeat (5) push_tick(1'b0);
        push_move(3, 16'hFFFF, 1'b1, 16'hFFFF);
        push_move(3, 16'd0, 1'b1, 16'd1);
        repeat (6) push_tick(1'b1);
        push_move(-4, 16'd2, 1'b0, 16'd1);
        repeat (4) push_tick(1'b0);
        push_move(-3, 16'd1, 1'b0, 16'd1);
        repeat (3) push_tick(1'b0);
        push_move(0, 16'd5, 1'b0, 16'd1);
        repeat (2) push_tick(1'b1);
        drain_results();

        // Random phases across register settings, extremes included
        run_random(120, 1'b1);
        write_config(16'h0000, 32'h0000_0000);
        run_random(100, 1'b0);
        write_config(16'hFFFF, 32'hFFFF_FFFF);
        run_random(80, 1'b0);
        write_config(16'($urandom_range(0, 12)), $urandom);
        run_random(120, 1'b0);
        write_config(MIN_STEPS_RST, PATTERN_RST);
        run_random(80, 1'b0);

        // Switch cannot stop at the largest min_steps; then a threshold just below it
        write_config(16'hFFFF, $urandom);
        push_move(1, 16'd0, 1'b1, 16'd1);
        repeat (20) push_tick(1'($urandom_range(0, 1)));
        drain_results();
        write_config(16'hFFFE, $urandom);
        push_tick(1'b1);
        push_tick(1'b0);
        drain_results();

        if (sb.mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
